// ----- rtl/hashflow_flow_record_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the flow record table
// Concurrent checks; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef HASHFLOW_FLOW_RECORD_TABLE_ASSERT_SVH
`define HASHFLOW_FLOW_RECORD_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define HFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hft assertion failed");
`define HFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hft assertion failed");
`else
`define HFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/hft_pkg.sv -----
// ----------------------------------------------------------------------------
// hft_pkg
// Shared constants, entry formats and helpers of the flow record table.
// ----------------------------------------------------------------------------
package hft_pkg;

    localparam int MAIN_DEPTH = 4096;
    localparam int AUX_DEPTH  = 1024;
    localparam int WAYS       = 3;
    localparam int RECORD_CAP = 40;

    localparam int MAIN_AW = $clog2(MAIN_DEPTH);
    localparam int AUX_AW  = $clog2(AUX_DEPTH);
    localparam int MR_AW   = $clog2(MAIN_DEPTH * RECORD_CAP);
    localparam int AR_AW   = $clog2(AUX_DEPTH * RECORD_CAP);
    localparam int RCNT_W  = $clog2(RECORD_CAP + 1);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int HC_W    = 4;

    localparam logic [31:0] MIX_C1   = 32'h7feb352d;
    localparam logic [31:0] MIX_C2   = 32'h846ca68b;
    localparam logic [31:0] AUX_SEED = 32'hDEADBEEF;
    localparam logic [31:0] CNT_MAX  = 32'hFFFFFFFF;

    localparam logic [7:0][31:0] WAY_SEED = {
        32'hA24BAEDF, 32'h94D049BB, 32'hD1B54A35, 32'h7F4A7C15,
        32'h9E3779B9, 32'hC001D00D, 32'hBADC0FFE, 32'h1234ABCD
    };

    localparam logic [2:0] OC_MAIN_INSERT = 3'd0;
    localparam logic [2:0] OC_MAIN_HIT    = 3'd1;
    localparam logic [2:0] OC_AUX_REPLACE = 3'd2;
    localparam logic [2:0] OC_AUX_INC     = 3'd3;
    localparam logic [2:0] OC_PROMOTE     = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [63:0]       addr_key;
        logic [39:0]       port_key;
        logic [31:0]       count;
        logic [RCNT_W-1:0] rcount;
        logic [47:0]       client;
    } t_entry;

    typedef struct packed {
        logic [51:0] times;
        logic [16:0] length;
    } t_rec;

    localparam int ENT_W = $bits(t_entry);
    localparam int REC_W = $bits(t_rec);

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        sat_inc = (c == CNT_MAX) ? CNT_MAX : c + 32'd1;
    endfunction

endpackage

// ----- rtl/hft_ram.sv -----
// ----------------------------------------------------------------------------
// hft_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hft_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/hft_mix.sv -----
// ----------------------------------------------------------------------------
// hft_mix
// Two-stage pipelined 32-bit mix hash, one multiplier per stage.
// ----------------------------------------------------------------------------
module hft_mix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_x,
    output logic        o_valid,
    output logic [31:0] o_y
);
    logic [31:0] r_p1, r_p2;
    logic        r_v1, r_v2;
    logic [31:0] a, b;

    assign a = i_x ^ (i_x >> 16);
    assign b = r_p1 ^ (r_p1 >> 15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_p1 <= a * hft_pkg::MIX_C1;
        r_p2 <= b * hft_pkg::MIX_C2;
    end

    assign o_valid = r_v2;
    assign o_y     = r_p2 ^ (r_p2 >> 16);
endmodule

// ----- rtl/hashflow_flow_record_table.sv -----
// ----------------------------------------------------------------------------
// hashflow_flow_record_table
// Per-packet flow accounting over a main and an auxiliary hash table.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry one packet beat (5-tuple, length,
// timestamp). Output channel: o_valid / i_ready carry one result beat per
// packet (outcome, table index, count, record slot and signed length).
// One packet is processed at a time. From accept to result beat a packet
// passes four key mixes and WAYS+1 seeded mixes through one two-stage
// multiplier pipeline, then an entry-RAM read and check per way (stopping
// at the first way that is empty or hits), the aux read and check, the
// record write and the output state. The next packet is accepted in the
// idle state that follows the output state. A promotion adds a copy of all
// RECORD_CAP aux record slots into the main record RAM before the record
// write. After reset the block runs a clearing pass over every address of
// the entry RAMs, with o_ready low. A stalled result beat holds in the
// output register; the next packet is accepted meanwhile and waits for it
// at the end of its own processing.
// ----------------------------------------------------------------------------
`include "hashflow_flow_record_table_assert.svh"
module hashflow_flow_record_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_src_ip,
    input  logic [31:0]        i_dst_ip,
    input  logic [15:0]        i_src_port,
    input  logic [15:0]        i_dst_port,
    input  logic [7:0]         i_protocol,
    input  logic [15:0]        i_ip_length,
    input  logic [31:0]        i_ts_seconds,
    input  logic [19:0]        i_ts_microseconds,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_outcome,
    output logic [11:0]        o_table_index,
    output logic [31:0]        o_flow_count,
    output logic               o_recorded,
    output logic [5:0]         o_record_slot,
    output logic signed [16:0] o_signed_length
);
    localparam int MAIN_AW = hft_pkg::MAIN_AW;
    localparam int AUX_AW  = hft_pkg::AUX_AW;
    localparam int MR_AW   = hft_pkg::MR_AW;
    localparam int AR_AW   = hft_pkg::AR_AW;
    localparam int RCNT_W  = hft_pkg::RCNT_W;
    localparam int WAY_W   = hft_pkg::WAY_W;
    localparam int HC_W    = hft_pkg::HC_W;
    localparam int WAYS    = hft_pkg::WAYS;
    localparam int CAP     = hft_pkg::RECORD_CAP;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_KEY, S_SEED, S_PROBE, S_PEVAL,
        S_AUXRD, S_AUXEV, S_COPY, S_REC, S_OUT
    } t_state;

    t_state r_state;
    logic [MAIN_AW-1:0] r_clr;
    logic [31:0] r_sip, r_dip, r_tsec;
    logic [15:0] r_sp, r_dp, r_len;
    logic [7:0]  r_proto;
    logic [19:0] r_tus;
    logic [31:0] r_x;
    logic [HC_W-1:0] r_feed, r_got;
    logic [MAIN_AW-1:0] r_main_idx [WAYS];
    logic [AUX_AW-1:0]  r_aux_idx;
    logic [WAY_W-1:0]   r_way;
    logic [31:0]        r_minc;
    logic               r_have_pos;
    logic [MAIN_AW-1:0] r_pos;
    hft_pkg::t_entry    r_ent;
    logic               r_tbl_aux;
    logic [MAIN_AW-1:0] r_idx;
    logic [2:0]         r_outcome;
    logic [RCNT_W:0]    r_cp, r_cp_d;
    logic               r_cp_wv;
    logic [AR_AW-1:0]   r_src_base;
    logic [MR_AW-1:0]   r_dst_base;
    logic               r_rec;
    logic [5:0]         r_slot;
    logic [16:0]        r_slen;
    logic               r_o_valid;
    logic [2:0]         r_o_outcome;
    logic [11:0]        r_o_index;
    logic [31:0]        r_o_count;
    logic               r_o_rec;
    logic [5:0]         r_o_slot;
    logic [16:0]        r_o_slen;

    logic        mix_v, mix_ov;
    logic [31:0] mix_x, mix_y;
    logic                 me_we, ae_we, mr_we, ar_we;
    logic [MAIN_AW-1:0]   me_wa, me_ra;
    logic [AUX_AW-1:0]    ae_wa;
    logic [MR_AW-1:0]     mr_wa;
    logic [AR_AW-1:0]     ar_wa, ar_ra;
    hft_pkg::t_entry      me_wd, ae_wd, me_rd, ae_rd;
    hft_pkg::t_rec        rec_wd, ar_rd;

    logic [63:0] ak;
    logic [39:0] pk;
    hft_pkg::t_entry new_ent, promo_ent;
    logic main_hit, aux_hit, aux_inc;
    logic [RCNT_W-1:0] n_rec;
    logic can_rec, is_client;
    logic [16:0] slen;
    logic [MR_AW-1:0] mr_rec_a;
    logic [AR_AW-1:0] ar_rec_a;
    logic out_free;

    assign ak = {r_sip, r_dip};
    assign pk = {r_sp, r_dp, r_proto};
    assign new_ent = '{valid: 1'b1, addr_key: ak, port_key: pk, count: 32'd1,
                       rcount: '0, client: {r_sip, r_sp}};
    assign promo_ent = '{valid: 1'b1, addr_key: ak, port_key: pk,
                         count: hft_pkg::sat_inc(ae_rd.count),
                         rcount: ae_rd.rcount, client: ae_rd.client};
    assign main_hit = me_rd.valid && me_rd.addr_key == ak && me_rd.port_key == pk;
    assign aux_hit  = ae_rd.valid && ae_rd.addr_key == ak && ae_rd.port_key == pk;
    assign aux_inc  = (ae_rd.count < r_minc) || !r_have_pos;

    assign n_rec     = r_ent.rcount;
    assign can_rec   = n_rec < RCNT_W'(CAP);
    assign is_client = r_ent.client == {r_sip, r_sp};
    assign slen      = is_client ? {1'b0, r_len} : 17'd0 - {1'b0, r_len};
    assign rec_wd    = '{times: {r_tsec, r_tus}, length: slen};
    assign mr_rec_a  = MR_AW'(r_idx) * MR_AW'(CAP) + MR_AW'(n_rec);
    assign ar_rec_a  = AR_AW'(r_idx[AUX_AW-1:0]) * AR_AW'(CAP) + AR_AW'(n_rec);
    assign out_free  = !r_o_valid || i_ready;

    always_comb begin
        mix_v = 1'b0;
        mix_x = '0;
        if (r_state == S_KEY && r_feed < HC_W'(4)) begin
            mix_v = 1'b1;
            case (r_feed[1:0])
                2'd0:    mix_x = r_sip;
                2'd1:    mix_x = r_dip;
                2'd2:    mix_x = {r_sp, r_dp};
                default: mix_x = {24'd0, r_proto};
            endcase
        end else if (r_state == S_SEED && r_feed <= HC_W'(WAYS)) begin
            mix_v = 1'b1;
            mix_x = r_x ^ ((r_feed < HC_W'(WAYS)) ? hft_pkg::WAY_SEED[r_feed[2:0]]
                                                  : hft_pkg::AUX_SEED);
        end
    end

    always_comb begin
        me_we = 1'b0;
        me_wa = r_main_idx[r_way];
        me_wd = new_ent;
        ae_we = 1'b0;
        ae_wa = r_aux_idx;
        ae_wd = new_ent;
        mr_we = 1'b0;
        mr_wa = mr_rec_a;
        ar_we = 1'b0;
        ar_wa = ar_rec_a;
        unique case (r_state)
            S_CLEAR: begin
                me_we = 1'b1;
                me_wa = r_clr;
                me_wd = '0;
                ae_we = r_clr < MAIN_AW'(hft_pkg::AUX_DEPTH);
                ae_wa = r_clr[AUX_AW-1:0];
                ae_wd = '0;
            end
            S_PEVAL: begin
                if (!me_rd.valid) begin
                    me_we = 1'b1;
                end else if (main_hit) begin
                    me_we = 1'b1;
                    me_wd = me_rd;
                    me_wd.count = hft_pkg::sat_inc(me_rd.count);
                end
            end
            S_AUXEV: begin
                if (!aux_hit) begin
                    ae_we = 1'b1;
                end else if (aux_inc) begin
                    ae_we = 1'b1;
                    ae_wd = ae_rd;
                    ae_wd.count = hft_pkg::sat_inc(ae_rd.count);
                end else begin
                    me_we = 1'b1;
                    me_wa = r_pos;
                    me_wd = promo_ent;
                end
            end
            S_COPY: begin
                mr_we = r_cp_wv;
                mr_wa = r_dst_base + MR_AW'(r_cp_d);
            end
            S_REC: begin
                if (can_rec) begin
                    me_we = !r_tbl_aux;
                    me_wa = r_idx;
                    me_wd = r_ent;
                    me_wd.rcount = n_rec + RCNT_W'(1);
                    ae_we = r_tbl_aux;
                    ae_wa = r_idx[AUX_AW-1:0];
                    ae_wd = me_wd;
                    mr_we = !r_tbl_aux;
                    ar_we = r_tbl_aux;
                end
            end
            default: ;
        endcase
    end

    assign me_ra = r_main_idx[r_way];
    assign ar_ra = r_src_base + AR_AW'(r_cp);

    hft_mix u_mix (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(mix_v), .i_x(mix_x),
        .o_valid(mix_ov), .o_y(mix_y)
    );

    hft_ram #(.W(hft_pkg::ENT_W), .D(hft_pkg::MAIN_DEPTH)) u_main_ent (
        .i_clk(i_clk), .i_we(me_we), .i_waddr(me_wa), .i_wdata(me_wd),
        .i_raddr(me_ra), .o_rdata(me_rd)
    );

    hft_ram #(.W(hft_pkg::ENT_W), .D(hft_pkg::AUX_DEPTH)) u_aux_ent (
        .i_clk(i_clk), .i_we(ae_we), .i_waddr(ae_wa), .i_wdata(ae_wd),
        .i_raddr(r_aux_idx), .o_rdata(ae_rd)
    );

    hft_ram #(.W(hft_pkg::REC_W), .D(hft_pkg::MAIN_DEPTH * CAP)) u_main_rec (
        .i_clk(i_clk), .i_we(mr_we), .i_waddr(mr_wa),
        .i_wdata(r_state == S_COPY ? ar_rd : rec_wd),
        .i_raddr('0), .o_rdata()
    );

    hft_ram #(.W(hft_pkg::REC_W), .D(hft_pkg::AUX_DEPTH * CAP)) u_aux_rec (
        .i_clk(i_clk), .i_we(ar_we), .i_waddr(ar_wa), .i_wdata(rec_wd),
        .i_raddr(ar_ra), .o_rdata(ar_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
            r_feed    <= '0;
            r_got     <= '0;
            r_way     <= '0;
            r_cp_wv   <= 1'b0;
        end else begin
            r_o_valid <= (r_state == S_OUT && out_free) || (r_o_valid && !i_ready);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + MAIN_AW'(1);
                    if (r_clr == MAIN_AW'(hft_pkg::MAIN_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_sip   <= i_src_ip;
                        r_dip   <= i_dst_ip;
                        r_sp    <= i_src_port;
                        r_dp    <= i_dst_port;
                        r_proto <= i_protocol;
                        r_len   <= i_ip_length;
                        r_tsec  <= i_ts_seconds;
                        r_tus   <= i_ts_microseconds;
                        r_x     <= '0;
                        r_feed  <= '0;
                        r_got   <= '0;
                        r_state <= S_KEY;
                    end
                end
                S_KEY: begin
                    if (mix_ov && r_got == HC_W'(3)) begin
                        r_x     <= r_x ^ mix_y;
                        r_feed  <= '0;
                        r_got   <= '0;
                        r_state <= S_SEED;
                    end else begin
                        if (mix_v) begin
                            r_feed <= r_feed + HC_W'(1);
                        end
                        if (mix_ov) begin
                            r_x   <= r_x ^ mix_y;
                            r_got <= r_got + HC_W'(1);
                        end
                    end
                end
                S_SEED: begin
                    if (mix_v) begin
                        r_feed <= r_feed + HC_W'(1);
                    end
                    if (mix_ov) begin
                        r_got <= r_got + HC_W'(1);
                        for (int i = 0; i < WAYS; i++) begin
                            if (r_got == HC_W'(i)) begin
                                r_main_idx[i] <= mix_y[MAIN_AW-1:0];
                            end
                        end
                        if (r_got == HC_W'(WAYS)) begin
                            r_aux_idx  <= mix_y[AUX_AW-1:0];
                            r_way      <= '0;
                            r_minc     <= hft_pkg::CNT_MAX;
                            r_have_pos <= 1'b0;
                            r_state    <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    r_state <= S_PEVAL;
                end
                S_PEVAL: begin
                    r_idx     <= r_main_idx[r_way];
                    r_tbl_aux <= 1'b0;
                    if (!me_rd.valid) begin
                        r_ent     <= new_ent;
                        r_outcome <= hft_pkg::OC_MAIN_INSERT;
                        r_state   <= S_REC;
                    end else if (main_hit) begin
                        r_ent     <= me_wd;
                        r_outcome <= hft_pkg::OC_MAIN_HIT;
                        r_state   <= S_REC;
                    end else begin
                        if (me_rd.count < r_minc) begin
                            r_minc     <= me_rd.count;
                            r_pos      <= r_main_idx[r_way];
                            r_have_pos <= 1'b1;
                        end
                        if (r_way == WAY_W'(WAYS - 1)) begin
                            r_state <= S_AUXRD;
                        end else begin
                            r_way   <= r_way + WAY_W'(1);
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_AUXRD: begin
                    r_state <= S_AUXEV;
                end
                S_AUXEV: begin
                    if (!aux_hit) begin
                        r_ent     <= new_ent;
                        r_outcome <= hft_pkg::OC_AUX_REPLACE;
                        r_tbl_aux <= 1'b1;
                        r_idx     <= MAIN_AW'(r_aux_idx);
                        r_state   <= S_REC;
                    end else if (aux_inc) begin
                        r_ent     <= ae_wd;
                        r_outcome <= hft_pkg::OC_AUX_INC;
                        r_tbl_aux <= 1'b1;
                        r_idx     <= MAIN_AW'(r_aux_idx);
                        r_state   <= S_REC;
                    end else begin
                        r_ent      <= promo_ent;
                        r_outcome  <= hft_pkg::OC_PROMOTE;
                        r_tbl_aux  <= 1'b0;
                        r_idx      <= r_pos;
                        r_src_base <= AR_AW'(r_aux_idx) * AR_AW'(CAP);
                        r_dst_base <= MR_AW'(r_pos) * MR_AW'(CAP);
                        r_cp       <= '0;
                        r_cp_wv    <= 1'b0;
                        r_state    <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (r_cp == (RCNT_W + 1)'(CAP)) begin
                        r_cp_wv <= 1'b0;
                        r_state <= S_REC;
                    end else begin
                        r_cp    <= r_cp + (RCNT_W + 1)'(1);
                        r_cp_d  <= r_cp;
                        r_cp_wv <= 1'b1;
                    end
                end
                S_REC: begin
                    r_rec   <= can_rec;
                    r_slot  <= can_rec ? 6'(n_rec) : 6'd0;
                    r_slen  <= can_rec ? slen : 17'd0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_outcome <= r_outcome;
                        r_o_index   <= 12'(r_idx);
                        r_o_count   <= r_ent.count;
                        r_o_rec     <= r_rec;
                        r_o_slot    <= r_slot;
                        r_o_slen    <= r_slen;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = r_state == S_IDLE;
    assign o_valid         = r_o_valid;
    assign o_outcome       = r_o_outcome;
    assign o_table_index   = r_o_index;
    assign o_flow_count    = r_o_count;
    assign o_recorded      = r_o_rec;
    assign o_record_slot   = r_o_slot;
    assign o_signed_length = $signed(r_o_slen);

    `HFT_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready, r_state == S_KEY)
    `HFT_ASSERT_IMP(a_clear_blocks, i_clk, i_rst_n, r_state == S_CLEAR, !o_ready)
    `HFT_ASSERT_IMP(a_way_range, i_clk, i_rst_n, r_state == S_PEVAL, r_way < WAY_W'(WAYS))
    `HFT_ASSERT_IMP(a_copy_range, i_clk, i_rst_n, r_state == S_COPY,
        r_cp <= (RCNT_W + 1)'(CAP))
endmodule

// ----- tb/hashflow_flow_record_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flow record table testbench
// Packets are driven through the input channel with random gaps. A local
// flow-table predictor computes the result beat for each accepted packet, and
// result beats are compared field by field, in order. Most random packets
// come from groups whose source and destination address are equal, so that
// every member of a group hashes to the same main and aux slots. This forces
// way collisions, aux replacement, aux increments and promotions. A few heavy
// flows repeat often enough to fill their record arrays.
// ----------------------------------------------------------------------------
module hashflow_flow_record_table_tb;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int N_RANDOM     = 1080;
    localparam int N_GROUPS     = 6;
    localparam int N_MEMBERS    = 6;
    localparam int N_HEAVY      = 3;

    typedef struct {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0]  proto;
        logic [15:0] len;
        logic [31:0] sec;
        logic [19:0] usec;
    } t_pkt;

    typedef struct {
        logic [2:0]  outcome;
        logic [11:0] index;
        logic [31:0] count;
        logic        recorded;
        logic [5:0]  slot;
        logic [16:0] slen;
    } t_flow_res;

    typedef struct {
        logic        valid;
        logic [63:0] ak;
        logic [39:0] pk;
        logic [31:0] cnt;
        int          rc;
        logic [47:0] client;
    } t_flow_ent;

    function automatic logic [31:0] mix32(logic [31:0] x);
        x = x ^ (x >> 16);
        x = x * hft_pkg::MIX_C1;
        x = x ^ (x >> 15);
        x = x * hft_pkg::MIX_C2;
        x = x ^ (x >> 16);
        return x;
    endfunction

    function automatic logic [31:0] tuple_hash(t_pkt p, logic [31:0] seed);
        logic [31:0] h;
        h = seed ^ mix32(p.sip) ^ mix32(p.dip) ^ mix32({p.sp, p.dp})
            ^ mix32({24'd0, p.proto});
        return mix32(h);
    endfunction

    class flow_scoreboard;
        t_flow_ent main_tab[hft_pkg::MAIN_DEPTH];
        t_flow_ent aux_tab[hft_pkg::AUX_DEPTH];
        t_flow_res pending_q[$];
        int        errors;

        function new();
            errors = 0;
            for (int i = 0; i < hft_pkg::MAIN_DEPTH; i++) main_tab[i].valid = 1'b0;
            for (int i = 0; i < hft_pkg::AUX_DEPTH; i++) aux_tab[i].valid = 1'b0;
        endfunction

        function void fresh(ref t_flow_ent e, input t_pkt p);
            e.valid  = 1'b1;
            e.ak     = {p.sip, p.dip};
            e.pk     = {p.sp, p.dp, p.proto};
            e.cnt    = 32'd1;
            e.rc     = 0;
            e.client = {p.sip, p.sp};
        endfunction

        function void log_packet(ref t_flow_ent e, input t_pkt p, ref t_flow_res r);
            r.recorded = 1'b0;
            r.slot     = '0;
            r.slen     = '0;
            if (e.rc < hft_pkg::RECORD_CAP) begin
                r.recorded = 1'b1;
                r.slot     = e.rc[5:0];
                if (e.client[47:16] == p.sip && e.client[15:0] == p.sp) begin
                    r.slen = {1'b0, p.len};
                end else begin
                    r.slen = 17'd0 - {1'b0, p.len};
                end
                e.rc++;
            end
            r.count = e.cnt;
        endfunction

        function void note(t_pkt p);
            t_flow_res   r;
            logic [63:0] ak;
            logic [39:0] pk;
            logic [31:0] minc;
            int          pos, idx, a;
            bit          have_pos, done;
            ak       = {p.sip, p.dip};
            pk       = {p.sp, p.dp, p.proto};
            minc     = hft_pkg::CNT_MAX;
            pos      = 0;
            have_pos = 0;
            done     = 0;
            for (int w = 0; w < hft_pkg::WAYS && !done; w++) begin
                idx = tuple_hash(p, hft_pkg::WAY_SEED[w & 7]) % hft_pkg::MAIN_DEPTH;
                if (!main_tab[idx].valid) begin
                    fresh(main_tab[idx], p);
                    r.outcome = hft_pkg::OC_MAIN_INSERT;
                    done = 1;
                end else if (main_tab[idx].ak == ak && main_tab[idx].pk == pk) begin
                    main_tab[idx].cnt = hft_pkg::sat_inc(main_tab[idx].cnt);
                    r.outcome = hft_pkg::OC_MAIN_HIT;
                    done = 1;
                end else if (main_tab[idx].cnt < minc) begin
                    minc = main_tab[idx].cnt;
                    pos = idx;
                    have_pos = 1;
                end
            end
            if (done) begin
                r.index = idx[11:0];
                log_packet(main_tab[idx], p, r);
            end else begin
                a = tuple_hash(p, hft_pkg::AUX_SEED) % hft_pkg::AUX_DEPTH;
                if (!aux_tab[a].valid || aux_tab[a].ak != ak || aux_tab[a].pk != pk) begin
                    fresh(aux_tab[a], p);
                    r.outcome = hft_pkg::OC_AUX_REPLACE;
                    r.index = a[11:0];
                    log_packet(aux_tab[a], p, r);
                end else if (aux_tab[a].cnt < minc || !have_pos) begin
                    aux_tab[a].cnt = hft_pkg::sat_inc(aux_tab[a].cnt);
                    r.outcome = hft_pkg::OC_AUX_INC;
                    r.index = a[11:0];
                    log_packet(aux_tab[a], p, r);
                end else begin
                    main_tab[pos] = aux_tab[a];
                    main_tab[pos].cnt = hft_pkg::sat_inc(aux_tab[a].cnt);
                    r.outcome = hft_pkg::OC_PROMOTE;
                    r.index = pos[11:0];
                    log_packet(main_tab[pos], p, r);
                end
            end
            pending_q.push_back(r);
        endfunction

        function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name,
                         exp_v, act_v);
            end
        endfunction

        function void check(t_flow_res act);
            t_flow_res e;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, outcome %0d index %0d",
                         $time, act.outcome, act.index);
                return;
            end
            e = pending_q.pop_front();
            field("outcome", e.outcome, act.outcome);
            field("table_index", e.index, act.index);
            field("flow_count", e.count, act.count);
            field("recorded", e.recorded, act.recorded);
            field("record_slot", e.slot, act.slot);
            field("signed_length", e.slen, act.slen);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [31:0]        i_src_ip;
    logic [31:0]        i_dst_ip;
    logic [15:0]        i_src_port;
    logic [15:0]        i_dst_port;
    logic [7:0]         i_protocol;
    logic [15:0]        i_ip_length;
    logic [31:0]        i_ts_seconds;
    logic [19:0]        i_ts_microseconds;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [2:0]         o_outcome;
    logic [11:0]        o_table_index;
    logic [31:0]        o_flow_count;
    logic               o_recorded;
    logic [5:0]         o_record_slot;
    logic signed [16:0] o_signed_length;

    hashflow_flow_record_table u_top (.*);

    flow_scoreboard sb;
    bit             quiet;
    int             stall_left;
    int             cycles;
    int             rx_gap;
    t_pkt           heavy[N_HEAVY];
    logic [31:0]    grp_ip[N_GROUPS][N_MEMBERS];
    logic [15:0]    grp_sp[N_GROUPS];
    logic [15:0]    grp_dp[N_GROUPS];
    logic [7:0]     grp_proto[N_GROUPS];

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check('{o_outcome, o_table_index, o_flow_count, o_recorded,
                       o_record_slot, o_signed_length});
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            rx_gap = pick_gap();
            i_ready <= (rx_gap == 0);
            stall_left <= (rx_gap > 0) ? rx_gap - 1 : 0;
        end
    end

    function automatic t_pkt rand_pkt();
        t_pkt p;
        p.sip   = $urandom();
        p.dip   = $urandom();
        p.sp    = $urandom();
        p.dp    = $urandom();
        p.proto = $urandom();
        p.len   = $urandom();
        p.sec   = $urandom();
        p.usec  = $urandom_range(0, 999999);
        return p;
    endfunction

    function automatic t_pkt group_pkt(int g, int m);
        t_pkt p;
        p       = rand_pkt();
        p.sip   = grp_ip[g][m];
        p.dip   = grp_ip[g][m];
        p.sp    = grp_sp[g];
        p.dp    = grp_dp[g];
        p.proto = grp_proto[g];
        return p;
    endfunction

    task automatic send(t_pkt p);
        int gap;
        i_valid           <= 1'b1;
        i_src_ip          <= p.sip;
        i_dst_ip          <= p.dip;
        i_src_port        <= p.sp;
        i_dst_port        <= p.dp;
        i_protocol        <= p.proto;
        i_ip_length       <= p.len;
        i_ts_seconds      <= p.sec;
        i_ts_microseconds <= p.usec;
        do @(posedge i_clk); while (!o_ready);
        sb.note(p);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_pkt p;
        int   r;
        sb                = new();
        quiet             = 0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_src_ip          = '0;
        i_dst_ip          = '0;
        i_src_port        = '0;
        i_dst_port        = '0;
        i_protocol        = '0;
        i_ip_length       = '0;
        i_ts_seconds      = '0;
        i_ts_microseconds = '0;
        for (int g = 0; g < N_GROUPS; g++) begin
            grp_sp[g]    = $urandom();
            grp_dp[g]    = $urandom();
            grp_proto[g] = $urandom();
            for (int m = 0; m < N_MEMBERS; m++) grp_ip[g][m] = $urandom();
        end
        for (int h = 0; h < N_HEAVY; h++) heavy[h] = rand_pkt();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes
        p = '{32'd0, 32'd0, 16'd0, 16'd0, 8'd0, 16'd0, 32'd0, 20'd0};
        send(p);
        send(p);
        p = '{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF,
              32'hFFFFFFFF, 20'd999999};
        send(p);
        // fill the ways of one group, then aux replace, promote, aux increment
        for (int m = 0; m < 3; m++) send(group_pkt(0, m));
        send(group_pkt(0, 3));
        send(group_pkt(0, 3));
        send(group_pkt(0, 4));
        for (int m = 0; m < 3; m++) send(group_pkt(0, m));
        send(group_pkt(0, 3));
        send(group_pkt(0, 5));
        send(group_pkt(0, 5));
        send(group_pkt(0, 5));
        send(group_pkt(0, 4));
        send(group_pkt(0, 4));
        // swapped addresses share every hash
        p = rand_pkt();
        send(p);
        {p.sip, p.dip} = {p.dip, p.sip};
        send(p);

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 300 && n < 420);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                p = group_pkt($urandom_range(0, N_GROUPS - 1),
                              $urandom_range(0, N_MEMBERS - 1));
            end else if (r < 78) begin
                p = heavy[$urandom_range(0, N_HEAVY - 1)];
                p.len  = $urandom();
                p.sec  = $urandom();
                p.usec = $urandom_range(0, 999999);
            end else begin
                p = rand_pkt();
            end
            send(p);
        end
        i_valid <= 1'b0;
        quiet = 0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
